// ----- rtl/ready_queue_with_aging_sort_macros.svh -----
// ----------------------------------------------------------------------------
// ready queue assertion macros
// concurrent assertion helpers clocked on clk_i, disabled in reset
// ----------------------------------------------------------------------------
`ifndef READY_QUEUE_WITH_AGING_SORT_MACROS_SVH
`define READY_QUEUE_WITH_AGING_SORT_MACROS_SVH

// same-cycle implication
`define RQAS_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("ready queue assertion failed");

// next-cycle implication
`define RQAS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("ready queue assertion failed");

`endif

// ----- rtl/rqas_pkg.sv -----
// ----------------------------------------------------------------------------
// rqas_pkg
// shared codes and default sizes of the ready queue
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package rqas_pkg;

  localparam int unsigned DEPTH_DEF      = 16;
  localparam int unsigned ID_BITS_DEF    = 8;
  localparam int unsigned SCORE_BITS_DEF = 16;
  localparam int unsigned FUNC_W         = 3;
  localparam int unsigned STATUS_W       = 2;

  typedef enum logic [FUNC_W-1:0] {
    FN_ENQ_TAIL = 3'd0,
    FN_ENQ_HEAD = 3'd1,
    FN_DEQ      = 3'd2,
    FN_AGE      = 3'd3,
    FN_SORT     = 3'd4
  } func_e;

  typedef enum logic [STATUS_W-1:0] {
    STS_DONE  = 2'd0,
    STS_EMPTY = 2'd1,
    STS_FULL  = 2'd2
  } status_e;

endpackage

`default_nettype wire

// ----- rtl/rqas_ram.sv -----
// ----------------------------------------------------------------------------
// rqas_ram
// ring payload store, one write port and two registered read ports
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rqas_ram #(
  parameter int unsigned DEPTH = rqas_pkg::DEPTH_DEF,
  parameter int unsigned WIDTH = rqas_pkg::ID_BITS_DEF + rqas_pkg::SCORE_BITS_DEF
) (
  input  wire logic                     clk_i,
  input  wire logic [$clog2(DEPTH)-1:0] ra_i,
  input  wire logic [$clog2(DEPTH)-1:0] rb_i,
  output logic      [WIDTH-1:0]         rd_a_o,
  output logic      [WIDTH-1:0]         rd_b_o,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] wa_i,
  input  wire logic [WIDTH-1:0]         wd_i
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[wa_i] <= wd_i;
    end
    rd_a_o <= mem[ra_i];
    rd_b_o <= mem[rb_i];
  end

endmodule

`default_nettype wire

// ----- rtl/ready_queue_with_aging_sort.sv -----
// enqueue and unused codes finish in S_DISP; a dequeue of a non-empty queue finishes in S_DEQ; done_o is registered
// age of N entries: one read (S_AGE_RD) and one write (S_AGE_WR) per entry on the ring store
// sort of N >= 2 entries: passes through S_SRT_CUR, S_SRT_LOAD, S_SRT_SCAN and S_SRT_SWAP, at most N - 1 swaps
// one item at a time; a new item can be taken in the cycle that done_o pulses
// results cannot be stalled; async reset empties the queue, ring contents stay undefined
// ----------------------------------------------------------------------------
// ready_queue_with_aging_sort
// bounded ring of job entries with enqueue, dequeue, aging and selection sort
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "ready_queue_with_aging_sort_macros.svh"

module ready_queue_with_aging_sort #(
  parameter int unsigned DEPTH      = rqas_pkg::DEPTH_DEF,
  parameter int unsigned ID_BITS    = rqas_pkg::ID_BITS_DEF,
  parameter int unsigned SCORE_BITS = rqas_pkg::SCORE_BITS_DEF
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          start,
  output logic                               busy,
  input  wire logic [rqas_pkg::FUNC_W-1:0]   func_i,
  input  wire logic [ID_BITS-1:0]            job_id_i,
  input  wire logic [SCORE_BITS-1:0]         job_score_i,
  output logic                               done_o,
  output logic      [rqas_pkg::STATUS_W-1:0] status_o,
  output logic      [ID_BITS-1:0]            out_id_o,
  output logic      [SCORE_BITS-1:0]         out_score_o
);

  localparam int unsigned IDX_W  = $clog2(DEPTH);
  localparam int unsigned CNT_W  = $clog2(DEPTH + 1);
  localparam int unsigned WORD_W = ID_BITS + SCORE_BITS;

  typedef enum logic [9:0] {
    S_IDLE      = 10'b00_0000_0001,
    S_DISP      = 10'b00_0000_0010,
    S_DEQ       = 10'b00_0000_0100,
    S_AGE_RD    = 10'b00_0000_1000,
    S_AGE_WR    = 10'b00_0001_0000,
    S_SRT_CUR   = 10'b00_0010_0000,
    S_SRT_LOAD  = 10'b00_0100_0000,
    S_SRT_SCAN  = 10'b00_1000_0000,
    S_SRT_SWAP  = 10'b01_0000_0000,
    S_SRT_SWAP2 = 10'b10_0000_0000
  } state_e;

  state_e                     state_q, state_d;
  rqas_pkg::func_e            func_q;
  logic [ID_BITS-1:0]         id_q;
  logic [SCORE_BITS-1:0]      score_q;
  logic [IDX_W-1:0]           head_q, head_d;
  logic [CNT_W-1:0]           cnt_q, cnt_d;
  logic [CNT_W-1:0]           cur_q, cur_d;
  logic [CNT_W-1:0]           j_q, j_d;
  logic [IDX_W-1:0]           ms_q, ms_d;
  logic [IDX_W-1:0]           cs_q, cs_d;
  logic [WORD_W-1:0]          min_q, min_d;
  logic [WORD_W-1:0]          curw_q, curw_d;
  logic                       done_q, done_d;
  rqas_pkg::status_e          status_q, status_d;
  logic [ID_BITS-1:0]         oid_q, oid_d;
  logic [SCORE_BITS-1:0]      oscore_q, oscore_d;

  logic [IDX_W-1:0]           ra, rb, wa;
  logic                       we;
  logic [WORD_W-1:0]          wd, rd_a, rd_b;
  logic                       fin;
  rqas_pkg::status_e          fin_sts;
  logic [ID_BITS-1:0]         fin_id;
  logic [SCORE_BITS-1:0]      fin_score;
  logic [SCORE_BITS-1:0]      aged;
  logic                       accept;

  function automatic logic [IDX_W-1:0] slot_of(logic [IDX_W-1:0] hd, logic [CNT_W-1:0] pos);
    logic [CNT_W:0] sum;
    sum = (CNT_W + 1)'(hd) + (CNT_W + 1)'(pos);
    if (sum >= (CNT_W + 1)'(DEPTH)) begin
      sum = sum - (CNT_W + 1)'(DEPTH);
    end
    return sum[IDX_W-1:0];
  endfunction

  rqas_ram #(
    .DEPTH (DEPTH),
    .WIDTH (WORD_W)
  ) u_ram (
    .clk_i  (clk_i),
    .ra_i   (ra),
    .rb_i   (rb),
    .rd_a_o (rd_a),
    .rd_b_o (rd_b),
    .we_i   (we),
    .wa_i   (wa),
    .wd_i   (wd)
  );

  assign busy   = (state_q != S_IDLE);
  assign accept = start && !busy;
  assign aged   = rd_a[SCORE_BITS-1:0] -
                  SCORE_BITS'(rd_a[SCORE_BITS-1:0] != '0);

  always_comb begin
    state_d   = state_q;
    head_d    = head_q;
    cnt_d     = cnt_q;
    cur_d     = cur_q;
    j_d       = j_q;
    ms_d      = ms_q;
    cs_d      = cs_q;
    min_d     = min_q;
    curw_d    = curw_q;
    done_d    = 1'b0;
    status_d  = status_q;
    oid_d     = oid_q;
    oscore_d  = oscore_q;
    ra        = head_q;
    rb        = head_q;
    we        = 1'b0;
    wa        = head_q;
    wd        = {id_q, score_q};
    fin       = 1'b0;
    fin_sts   = rqas_pkg::STS_DONE;
    fin_id    = '0;
    fin_score = '0;

    case (state_q)
      S_IDLE: begin
        if (accept) begin
          state_d = S_DISP;
        end
      end
      S_DISP: begin
        case (func_q)
          rqas_pkg::FN_ENQ_TAIL: begin
            fin = 1'b1;
            if (cnt_q == CNT_W'(DEPTH)) begin
              fin_sts = rqas_pkg::STS_FULL;
            end else begin
              we    = 1'b1;
              wa    = slot_of(head_q, cnt_q);
              cnt_d = cnt_q + CNT_W'(1);
            end
          end
          rqas_pkg::FN_ENQ_HEAD: begin
            fin = 1'b1;
            if (cnt_q == CNT_W'(DEPTH)) begin
              fin_sts = rqas_pkg::STS_FULL;
            end else begin
              head_d = (head_q == '0) ? IDX_W'(DEPTH - 1) : head_q - IDX_W'(1);
              we     = 1'b1;
              wa     = head_d;
              cnt_d  = cnt_q + CNT_W'(1);
            end
          end
          rqas_pkg::FN_DEQ: begin
            if (cnt_q == '0) begin
              fin     = 1'b1;
              fin_sts = rqas_pkg::STS_EMPTY;
            end else begin
              ra      = head_q;
              state_d = S_DEQ;
            end
          end
          rqas_pkg::FN_AGE: begin
            if (cnt_q == '0) begin
              fin = 1'b1;
            end else begin
              cur_d   = '0;
              state_d = S_AGE_RD;
            end
          end
          rqas_pkg::FN_SORT: begin
            if (cnt_q < CNT_W'(2)) begin
              fin = 1'b1;
            end else begin
              cur_d   = '0;
              state_d = S_SRT_CUR;
            end
          end
          default: begin
            fin = 1'b1;
          end
        endcase
      end
      S_DEQ: begin
        fin       = 1'b1;
        fin_id    = rd_a[WORD_W-1:SCORE_BITS];
        fin_score = rd_a[SCORE_BITS-1:0];
        head_d    = (head_q == IDX_W'(DEPTH - 1)) ? '0 : head_q + IDX_W'(1);
        cnt_d     = cnt_q - CNT_W'(1);
      end
      S_AGE_RD: begin
        ra      = slot_of(head_q, cur_q);
        state_d = S_AGE_WR;
      end
      S_AGE_WR: begin
        we    = 1'b1;
        wa    = slot_of(head_q, cur_q);
        wd    = {rd_a[WORD_W-1:SCORE_BITS], aged};
        cur_d = cur_q + CNT_W'(1);
        if (cur_d == cnt_q) begin
          fin = 1'b1;
        end else begin
          state_d = S_AGE_RD;
        end
      end
      S_SRT_CUR: begin
        if (cur_q + CNT_W'(1) >= cnt_q) begin
          fin = 1'b1;
        end else begin
          ra      = slot_of(head_q, cur_q);
          j_d     = cur_q + CNT_W'(1);
          state_d = S_SRT_LOAD;
        end
      end
      S_SRT_LOAD: begin
        min_d   = rd_a;
        curw_d  = rd_a;
        cs_d    = slot_of(head_q, cur_q);
        ms_d    = cs_d;
        rb      = slot_of(head_q, j_q);
        state_d = S_SRT_SCAN;
      end
      S_SRT_SCAN: begin
        if (rd_b[SCORE_BITS-1:0] < min_q[SCORE_BITS-1:0]) begin
          min_d = rd_b;
          ms_d  = slot_of(head_q, j_q);
        end
        j_d = j_q + CNT_W'(1);
        if (j_d < cnt_q) begin
          rb = slot_of(head_q, j_d);
        end else begin
          state_d = S_SRT_SWAP;
        end
      end
      S_SRT_SWAP: begin
        if (ms_q != cs_q) begin
          we      = 1'b1;
          wa      = cs_q;
          wd      = min_q;
          state_d = S_SRT_SWAP2;
        end else begin
          cur_d   = cur_q + CNT_W'(1);
          state_d = S_SRT_CUR;
        end
      end
      S_SRT_SWAP2: begin
        we      = 1'b1;
        wa      = ms_q;
        wd      = curw_q;
        cur_d   = cur_q + CNT_W'(1);
        state_d = S_SRT_CUR;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    if (fin) begin
      state_d  = S_IDLE;
      done_d   = 1'b1;
      status_d = fin_sts;
      oid_d    = fin_id;
      oscore_d = fin_score;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      head_q  <= '0;
      cnt_q   <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      head_q  <= head_d;
      cnt_q   <= cnt_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      func_q  <= rqas_pkg::func_e'(func_i);
      id_q    <= job_id_i;
      score_q <= job_score_i;
    end
    cur_q    <= cur_d;
    j_q      <= j_d;
    ms_q     <= ms_d;
    cs_q     <= cs_d;
    min_q    <= min_d;
    curw_q   <= curw_d;
    status_q <= status_d;
    oid_q    <= oid_d;
    oscore_q <= oscore_d;
  end

  assign done_o      = done_q;
  assign status_o    = status_q;
  assign out_id_o    = oid_q;
  assign out_score_o = oscore_q;

  `RQAS_ASSERT_SAME(a_cnt_bound, 1'b1, cnt_q <= CNT_W'(DEPTH))
  `RQAS_ASSERT_NEXT(a_accept_busy, accept, busy && !done_o)
  `RQAS_ASSERT_SAME(a_done_idle, done_o, !busy)
  `RQAS_ASSERT_SAME(a_empty_zero, done_o && status_o == rqas_pkg::STS_EMPTY, {out_id_o, out_score_o} == '0)

endmodule

`default_nettype wire

// ----- verif/tb.sv -----
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the ready queue: a local ring model predicts the
// status and dequeued entry of every beat; directed checks of the empty and
// full ring, score extremes, aging and sort ties are followed by random
// fill and drain sequences with random gaps on the sending side
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;

  localparam int unsigned DEPTH   = rqas_pkg::DEPTH_DEF;
  localparam int unsigned ID_W    = rqas_pkg::ID_BITS_DEF;
  localparam int unsigned SC_W    = rqas_pkg::SCORE_BITS_DEF;
  localparam int unsigned FN_W    = rqas_pkg::FUNC_W;
  localparam int unsigned ST_W    = rqas_pkg::STATUS_W;
  localparam int unsigned JOB_OPS = 1000;

  localparam logic [FN_W-1:0] FN_SPARE_5 = 3'd5;
  localparam logic [FN_W-1:0] FN_SPARE_6 = 3'd6;
  localparam logic [FN_W-1:0] FN_SPARE_7 = 3'd7;

  typedef struct {
    rqas_pkg::status_e status;
    logic [ID_W-1:0]   id;
    logic [SC_W-1:0]   score;
  } job_result_t;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              start = 1'b0;
  logic              busy;
  logic [FN_W-1:0]   func_i = '0;
  logic [ID_W-1:0]   job_id_i = '0;
  logic [SC_W-1:0]   job_score_i = '0;
  logic              done_o;
  logic [ST_W-1:0]   status_o;
  logic [ID_W-1:0]   out_id_o;
  logic [SC_W-1:0]   out_score_o;

  // ring model
  logic [ID_W-1:0] ring_ids [DEPTH];
  logic [SC_W-1:0] ring_scores [DEPTH];
  int              ring_head = 0;
  int              ring_count = 0;

  job_result_t pending_results [$];
  int          error_count = 0;

  ready_queue_with_aging_sort #(
    .DEPTH     (DEPTH),
    .ID_BITS   (ID_W),
    .SCORE_BITS(SC_W)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start      (start),
    .busy       (busy),
    .func_i     (func_i),
    .job_id_i   (job_id_i),
    .job_score_i(job_score_i),
    .done_o     (done_o),
    .status_o   (status_o),
    .out_id_o   (out_id_o),
    .out_score_o(out_score_o)
  );

  always #2 clk_i = ~clk_i;

  function automatic int slot_at(int pos);
    return (ring_head + pos) % DEPTH;
  endfunction

  function automatic job_result_t apply_job_op(logic [FN_W-1:0] fn, logic [ID_W-1:0] id,
                                               logic [SC_W-1:0] sc);
    job_result_t     r;
    int              s, cur, j, cs, ms, js;
    logic [ID_W-1:0] tid;
    logic [SC_W-1:0] tsc;
    r.status = rqas_pkg::STS_DONE;
    r.id     = '0;
    r.score  = '0;
    case (fn)
      rqas_pkg::FN_ENQ_TAIL: begin
        if (ring_count >= DEPTH) begin
          r.status = rqas_pkg::STS_FULL;
        end else begin
          s = slot_at(ring_count);
          ring_ids[s]    = id;
          ring_scores[s] = sc;
          ring_count++;
        end
      end
      rqas_pkg::FN_ENQ_HEAD: begin
        if (ring_count >= DEPTH) begin
          r.status = rqas_pkg::STS_FULL;
        end else begin
          ring_head = (ring_head + DEPTH - 1) % DEPTH;
          ring_ids[ring_head]    = id;
          ring_scores[ring_head] = sc;
          ring_count++;
        end
      end
      rqas_pkg::FN_DEQ: begin
        if (ring_count == 0) begin
          r.status = rqas_pkg::STS_EMPTY;
        end else begin
          r.id      = ring_ids[ring_head];
          r.score   = ring_scores[ring_head];
          ring_head = (ring_head + 1) % DEPTH;
          ring_count--;
        end
      end
      rqas_pkg::FN_AGE: begin
        for (cur = 0; cur < ring_count; cur++) begin
          s = slot_at(cur);
          if (ring_scores[s] != '0) ring_scores[s] = ring_scores[s] - 1'b1;
        end
      end
      rqas_pkg::FN_SORT: begin
        // selection sort on logical order, first strict minimum wins
        if (ring_count >= 2) begin
          for (cur = 0; cur < ring_count; cur++) begin
            cs = slot_at(cur);
            ms = cs;
            for (j = cur + 1; j < ring_count; j++) begin
              js = slot_at(j);
              if (ring_scores[js] < ring_scores[ms]) ms = js;
            end
            if (ms != cs) begin
              tid             = ring_ids[ms];
              ring_ids[ms]    = ring_ids[cs];
              ring_ids[cs]    = tid;
              tsc             = ring_scores[ms];
              ring_scores[ms] = ring_scores[cs];
              ring_scores[cs] = tsc;
            end
          end
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  // one beat: hold start until an edge with busy low
  task automatic send_job_op(logic [FN_W-1:0] fn, logic [ID_W-1:0] id, logic [SC_W-1:0] sc);
    @(negedge clk_i);
    start       <= 1'b1;
    func_i      <= fn;
    job_id_i    <= id;
    job_score_i <= sc;
    do @(posedge clk_i); while (busy);
    pending_results.push_back(apply_job_op(fn, id, sc));
  endtask

  task automatic idle_for(int n);
    repeat (n) begin
      @(negedge clk_i);
      start <= 1'b0;
    end
  endtask

  function automatic logic [SC_W-1:0] pick_score();
    case ($urandom_range(0, 3))
      0:       return SC_W'($urandom_range(0, 3));
      1:       return $urandom_range(0, 1) ? '1 : '0;
      default: return SC_W'($urandom());
    endcase
  endfunction

  function automatic logic [FN_W-1:0] pick_spare();
    case ($urandom_range(0, 2))
      0:       return FN_SPARE_5;
      1:       return FN_SPARE_6;
      default: return FN_SPARE_7;
    endcase
  endfunction

  always @(posedge clk_i) begin
    job_result_t e;
    if (rst_ni && done_o) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result status=%0d id=%0d score=%0d", $time, status_o,
                 out_id_o, out_score_o);
        error_count++;
      end else begin
        e = pending_results.pop_front();
        if (status_o !== e.status) begin
          $display("%0t: status expected %0d actual %0d", $time, e.status, status_o);
          error_count++;
        end
        if (out_id_o !== e.id) begin
          $display("%0t: out_id expected %0d actual %0d", $time, e.id, out_id_o);
          error_count++;
        end
        if (out_score_o !== e.score) begin
          $display("%0t: out_score expected %0d actual %0d", $time, e.score, out_score_o);
          error_count++;
        end
      end
    end
  end

  task automatic test_empty_queue();
    send_job_op(rqas_pkg::FN_DEQ, '1, '1);
    send_job_op(rqas_pkg::FN_SORT, '0, '0);
    send_job_op(rqas_pkg::FN_AGE, '1, '0);
    send_job_op(FN_SPARE_7, '1, '1);
  endtask

  task automatic test_extremes_age_sort();
    send_job_op(rqas_pkg::FN_ENQ_TAIL, '0, '0);
    send_job_op(rqas_pkg::FN_ENQ_HEAD, '1, '1);
    send_job_op(rqas_pkg::FN_ENQ_TAIL, ID_W'(8'h5a), SC_W'(2));
    send_job_op(rqas_pkg::FN_ENQ_TAIL, ID_W'(8'ha5), SC_W'(2));
    // zero score stays at zero, the tied entries keep their order through the sort
    send_job_op(rqas_pkg::FN_AGE, '0, '0);
    send_job_op(rqas_pkg::FN_SORT, '0, '0);
    send_job_op(rqas_pkg::FN_DEQ, '0, '0);
    send_job_op(rqas_pkg::FN_DEQ, '0, '0);
  endtask

  task automatic test_full_ring();
    while (ring_count < DEPTH) begin
      send_job_op(rqas_pkg::FN_ENQ_TAIL, ID_W'($urandom()), pick_score());
    end
    send_job_op(rqas_pkg::FN_ENQ_TAIL, '1, '1);
    send_job_op(rqas_pkg::FN_ENQ_HEAD, '1, '1);
  endtask

  task automatic test_random_traffic();
    int              done_ops, burst_left, roll;
    bit              filling;
    logic [FN_W-1:0] fn;
    done_ops   = 0;
    burst_left = 0;
    filling    = 0;
    while (done_ops < JOB_OPS) begin
      if (burst_left == 0) begin
        idle_for($urandom_range(1, 12));
        burst_left = ($urandom_range(0, 9) == 0) ? 150 : $urandom_range(1, 24);
      end
      burst_left--;
      if (ring_count == DEPTH && $urandom_range(0, 3) == 0) filling = 0;
      else if (ring_count == 0 && $urandom_range(0, 3) == 0) filling = 1;
      else if ($urandom_range(0, 29) == 0) filling = !filling;
      roll = $urandom_range(0, 99);
      if (roll < 3) fn = pick_spare();
      else if (roll < 10) fn = rqas_pkg::FN_AGE;
      else if (roll < 16) fn = rqas_pkg::FN_SORT;
      else if (filling ? roll < 30 : roll < 80) fn = rqas_pkg::FN_DEQ;
      else fn = $urandom_range(0, 1) ? rqas_pkg::FN_ENQ_HEAD : rqas_pkg::FN_ENQ_TAIL;
      if (fn != FN_SPARE_5 && fn != FN_SPARE_6 && fn != FN_SPARE_7) done_ops++;
      send_job_op(fn, ID_W'($urandom()), pick_score());
    end
    idle_for(1);
  endtask

  initial begin
    int guard;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    test_empty_queue();
    test_extremes_age_sort();
    test_full_ring();
    test_random_traffic();
    guard = 0;
    while (pending_results.size() != 0 && guard < 2000) begin
      @(posedge clk_i);
      guard++;
    end
    if (pending_results.size() != 0) begin
      $display("%0t: %0d results missing", $time, pending_results.size());
      error_count++;
    end
    repeat (16) @(posedge clk_i);
    if (error_count == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("tb: errors");
    $finish;
  end

endmodule
